@@ src/vc_pkg.sv @@
// Shared types, codes and reset constants for the vending controller.
// Used by every module of the block; depends on nothing.
package vc_pkg;

  localparam int NUM_ITEMS_DEF   = 4;
  localparam int CODE_DIGITS_DEF = 6;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] REG_PRICE_ONE     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PRICE_TWO     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PRICE_THREE   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PRICE_FOUR    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ADMIN_CODE    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RESTOCK_LEVEL = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MOTOR_TICKS   = 3'd6;

  localparam logic [7:0]  PRICE_ONE_RST     = 8'd4;
  localparam logic [7:0]  PRICE_TWO_RST     = 8'd6;
  localparam logic [7:0]  PRICE_THREE_RST   = 8'd5;
  localparam logic [7:0]  PRICE_FOUR_RST    = 8'd4;
  localparam logic [23:0] ADMIN_CODE_RST    = 24'h123456;
  localparam logic [7:0]  RESTOCK_LEVEL_RST = 8'd5;
  localparam logic [3:0]  MOTOR_TICKS_RST   = 4'd2;

  localparam logic [7:0]  WITHDRAW_COINS = 8'd20;
  localparam logic [1:0]  MSG_IDLE       = 2'd3;
  localparam logic [7:0]  CREDIT_MAX     = 8'hFF;
  localparam logic [15:0] BANK_MAX       = 16'hFFFF;
  localparam logic [3:0]  SEL_LIMIT      = 4'd9;

  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;

  typedef enum logic [1:0] {
    FUNC_KEY    = 2'd0,
    FUNC_COIN   = 2'd1,
    FUNC_REFUND = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_NONE       = 4'd0,
    ST_DISPENSED  = 4'd1,
    ST_NOT_ENOUGH = 4'd2,
    ST_NO_STOCK   = 4'd3,
    ST_CODE_OK    = 4'd4,
    ST_CODE_BAD   = 4'd5,
    ST_RESTOCKED  = 4'd6,
    ST_WITHDRAWN  = 4'd7,
    ST_MODE       = 4'd8,
    ST_DIGIT      = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    MODE_MAIN      = 3'd0,
    MODE_CODE      = 3'd1,
    MODE_ADMIN     = 3'd2,
    MODE_TEMP      = 3'd3,
    MODE_INVENTORY = 3'd4,
    MODE_CASH      = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0]  price_one;
    logic [7:0]  price_two;
    logic [7:0]  price_three;
    logic [7:0]  price_four;
    logic [23:0] admin_code;
    logic [7:0]  restock_level;
    logic [3:0]  motor_ticks;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  motor_enables;
    logic        servo_on;
    logic        red_led;
    logic        green_led;
    logic [7:0]  credit_quarters;
    logic [7:0]  change_quarters;
    mode_t       menu_mode;
    logic [15:0] bank_quarters;
  } result_t;

endpackage

@@ src/vc_cfg_regs.sv @@
// Configuration register file of the vending controller.
// Depends on vc_pkg for register indexes, reset values and cfg_t.
module vc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [vc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [vc_pkg::CFG_DW-1:0] cfg_wdata,
  output vc_pkg::cfg_t              cfg
);

  vc_pkg::cfg_t cfg_r;
  vc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        vc_pkg::REG_PRICE_ONE:     cfg_nxt.price_one     = cfg_wdata[7:0];
        vc_pkg::REG_PRICE_TWO:     cfg_nxt.price_two     = cfg_wdata[7:0];
        vc_pkg::REG_PRICE_THREE:   cfg_nxt.price_three   = cfg_wdata[7:0];
        vc_pkg::REG_PRICE_FOUR:    cfg_nxt.price_four    = cfg_wdata[7:0];
        vc_pkg::REG_ADMIN_CODE:    cfg_nxt.admin_code    = cfg_wdata[23:0];
        vc_pkg::REG_RESTOCK_LEVEL: cfg_nxt.restock_level = cfg_wdata[7:0];
        vc_pkg::REG_MOTOR_TICKS:   cfg_nxt.motor_ticks   = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.price_one     <= vc_pkg::PRICE_ONE_RST;
      cfg_r.price_two     <= vc_pkg::PRICE_TWO_RST;
      cfg_r.price_three   <= vc_pkg::PRICE_THREE_RST;
      cfg_r.price_four    <= vc_pkg::PRICE_FOUR_RST;
      cfg_r.admin_code    <= vc_pkg::ADMIN_CODE_RST;
      cfg_r.restock_level <= vc_pkg::RESTOCK_LEVEL_RST;
      cfg_r.motor_ticks   <= vc_pkg::MOTOR_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/vc_engine.sv @@
// Machine state and the single-pass event logic of the vending controller.
// Depends on vc_pkg; the state advances once per processed item.
module vc_engine #(
  parameter int NUM_ITEMS   = vc_pkg::NUM_ITEMS_DEF,
  parameter int CODE_DIGITS = vc_pkg::CODE_DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [1:0]      func,
  input  logic [3:0]      key,
  input  vc_pkg::cfg_t    cfg,
  output vc_pkg::result_t res
);

  localparam int PW = $clog2(CODE_DIGITS + 1);
  localparam logic [3:0] SEL_MAX =
    (NUM_ITEMS < 9) ? 4'(NUM_ITEMS) : vc_pkg::SEL_LIMIT;

  vc_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]    credit_r, credit_nxt;
  logic [7:0]    stock_r [NUM_ITEMS];
  logic [7:0]    stock_nxt [NUM_ITEMS];
  logic [15:0]   bank_r, bank_nxt;
  logic [3:0]    digits_r [CODE_DIGITS];
  logic [3:0]    digits_nxt [CODE_DIGITS];
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    coins_r, coins_nxt;
  logic [3:0]    motor_r, motor_nxt;
  logic [3:0]    mtimer_r, mtimer_nxt;
  logic [1:0]    msg_r, msg_nxt;
  logic [1:0]    lamps_r, lamps_nxt;
  logic          lock_r, lock_nxt;

  vc_pkg::status_t status;
  logic [7:0]      change;
  logic [31:0]     admin_ext;
  logic            code_ok;
  logic [3:0]      sel_idx;
  logic            sel_key;
  logic [7:0]      price;
  logic [7:0]      sel_stock;
  logic [16:0]     bank_sum;
  logic [PW-1:0]   wpos;
  logic [1:0]      msg_inc;

  always_comb begin
    admin_ext = {8'd0, cfg.admin_code};
    code_ok = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (digits_r[i] != admin_ext[4*(CODE_DIGITS-1-i) +: 4]) begin
        code_ok = 1'b0;
      end
    end
  end

  always_comb begin
    sel_idx = key - 4'd1;
    sel_key = (key >= 4'd1) && (key <= SEL_MAX);
    case (sel_idx)
      4'd0:    price = cfg.price_one;
      4'd1:    price = cfg.price_two;
      4'd2:    price = cfg.price_three;
      default: price = cfg.price_four;
    endcase
    sel_stock = 8'd0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (sel_idx == 4'(i)) begin
        sel_stock = stock_r[i];
      end
    end
    bank_sum = {1'b0, bank_r} + {9'd0, price};
    wpos = (pos_r >= PW'(CODE_DIGITS)) ? '0 : pos_r;
    msg_inc = msg_r + 2'd1;
  end

  always_comb begin
    mode_nxt   = mode_r;
    credit_nxt = credit_r;
    stock_nxt  = stock_r;
    bank_nxt   = bank_r;
    digits_nxt = digits_r;
    pos_nxt    = pos_r;
    coins_nxt  = coins_r;
    motor_nxt  = motor_r;
    mtimer_nxt = mtimer_r;
    msg_nxt    = msg_r;
    lamps_nxt  = lamps_r;
    lock_nxt   = lock_r;
    status     = vc_pkg::ST_NONE;
    change     = 8'd0;

    unique case (vc_pkg::func_t'(func))
      vc_pkg::FUNC_KEY: begin
        unique case (mode_r)
          vc_pkg::MODE_CODE: begin
            if (key == vc_pkg::KEY_HASH) begin
              pos_nxt = '0;
              if (code_ok) begin
                for (int i = 0; i < CODE_DIGITS; i++) begin
                  digits_nxt[i] = 4'd0;
                end
                mode_nxt = vc_pkg::MODE_ADMIN;
                status   = vc_pkg::ST_CODE_OK;
              end else begin
                status = vc_pkg::ST_CODE_BAD;
              end
            end else if (key == vc_pkg::KEY_STAR) begin
              mode_nxt  = vc_pkg::MODE_MAIN;
              msg_nxt   = vc_pkg::MSG_IDLE;
              lamps_nxt = 2'b00;
              lock_nxt  = 1'b0;
              status    = vc_pkg::ST_MODE;
            end else begin
              for (int i = 0; i < CODE_DIGITS; i++) begin
                if (wpos == PW'(i)) begin
                  digits_nxt[i] = key;
                end
              end
              pos_nxt = wpos + PW'(1);
              status  = vc_pkg::ST_DIGIT;
            end
          end
          vc_pkg::MODE_ADMIN: begin
            if (key == vc_pkg::KEY_STAR) begin
              mode_nxt  = vc_pkg::MODE_MAIN;
              msg_nxt   = vc_pkg::MSG_IDLE;
              lamps_nxt = 2'b00;
              lock_nxt  = 1'b0;
              status    = vc_pkg::ST_MODE;
            end else if ((key >= 4'd1) && (key <= 4'd3)) begin
              mode_nxt = vc_pkg::mode_t'(3'(key + 4'd2));
              status   = vc_pkg::ST_MODE;
            end
          end
          vc_pkg::MODE_TEMP: begin
            if (key == vc_pkg::KEY_STAR) begin
              mode_nxt = vc_pkg::MODE_ADMIN;
              status   = vc_pkg::ST_MODE;
            end
          end
          vc_pkg::MODE_INVENTORY: begin
            if (key == vc_pkg::KEY_STAR) begin
              mode_nxt = vc_pkg::MODE_ADMIN;
              status   = vc_pkg::ST_MODE;
            end else if (key == vc_pkg::KEY_HASH) begin
              for (int i = 0; i < NUM_ITEMS; i++) begin
                stock_nxt[i] = cfg.restock_level;
              end
              status = vc_pkg::ST_RESTOCKED;
            end
          end
          vc_pkg::MODE_CASH: begin
            if (key == vc_pkg::KEY_STAR) begin
              mode_nxt = vc_pkg::MODE_ADMIN;
              status   = vc_pkg::ST_MODE;
            end else if (key == vc_pkg::KEY_HASH) begin
              coins_nxt = vc_pkg::WITHDRAW_COINS;
              bank_nxt  = 16'd0;
              status    = vc_pkg::ST_WITHDRAWN;
            end
          end
          default: begin
            mode_nxt = vc_pkg::MODE_MAIN;
            if (lock_r) begin
              status = vc_pkg::ST_NONE;
            end else if (sel_key) begin
              msg_nxt = 2'd0;
              if (sel_stock == 8'd0) begin
                lamps_nxt = 2'b01;
                status    = vc_pkg::ST_NO_STOCK;
              end else begin
                lock_nxt = 1'b1;
                if (credit_r >= price) begin
                  for (int i = 0; i < NUM_ITEMS; i++) begin
                    if (sel_idx == 4'(i)) begin
                      stock_nxt[i] = stock_r[i] - 8'd1;
                    end
                  end
                  bank_nxt = bank_sum[16] ? vc_pkg::BANK_MAX : bank_sum[15:0];
                  if (sel_idx < 4'd4) begin
                    motor_nxt[sel_idx[1:0]] = 1'b1;
                    mtimer_nxt = 4'd0;
                  end
                  change     = credit_r - price;
                  coins_nxt  = credit_r - price;
                  credit_nxt = 8'd0;
                  lamps_nxt  = 2'b10;
                  status     = vc_pkg::ST_DISPENSED;
                end else begin
                  lamps_nxt = 2'b01;
                  status    = vc_pkg::ST_NOT_ENOUGH;
                end
              end
            end else if (key == vc_pkg::KEY_STAR) begin
              mode_nxt = vc_pkg::MODE_CODE;
              pos_nxt  = '0;
              status   = vc_pkg::ST_MODE;
            end
          end
        endcase
      end
      vc_pkg::FUNC_COIN: begin
        if (credit_r != vc_pkg::CREDIT_MAX) begin
          credit_nxt = credit_r + 8'd1;
        end
      end
      vc_pkg::FUNC_REFUND: begin
        if (mode_r == vc_pkg::MODE_MAIN) begin
          credit_nxt = 8'd0;
        end
      end
      default: begin
        if (msg_r != vc_pkg::MSG_IDLE) begin
          msg_nxt = msg_inc;
          if (msg_inc == vc_pkg::MSG_IDLE) begin
            lamps_nxt = 2'b00;
            lock_nxt  = 1'b0;
          end
        end
        if (motor_r != 4'd0) begin
          if (mtimer_r >= cfg.motor_ticks) begin
            motor_nxt  = 4'd0;
            mtimer_nxt = 4'd0;
          end else begin
            mtimer_nxt = mtimer_r + 4'd1;
          end
        end
        if (coins_r != 8'd0) begin
          coins_nxt = coins_r - 8'd1;
        end
      end
    endcase
  end

  always_comb begin
    res.status          = status;
    res.motor_enables   = motor_nxt;
    res.servo_on        = (coins_nxt != 8'd0);
    res.red_led         = lamps_nxt[0];
    res.green_led       = lamps_nxt[1];
    res.credit_quarters = credit_nxt;
    res.change_quarters = change;
    res.menu_mode       = mode_nxt;
    res.bank_quarters   = bank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= vc_pkg::MODE_MAIN;
      credit_r <= 8'd0;
      for (int i = 0; i < NUM_ITEMS; i++) begin
        stock_r[i] <= vc_pkg::RESTOCK_LEVEL_RST;
      end
      bank_r <= 16'd0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        digits_r[i] <= 4'd0;
      end
      pos_r    <= '0;
      coins_r  <= 8'd0;
      motor_r  <= 4'd0;
      mtimer_r <= 4'd0;
      msg_r    <= vc_pkg::MSG_IDLE;
      lamps_r  <= 2'b00;
      lock_r   <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      credit_r <= credit_nxt;
      stock_r  <= stock_nxt;
      bank_r   <= bank_nxt;
      digits_r <= digits_nxt;
      pos_r    <= pos_nxt;
      coins_r  <= coins_nxt;
      motor_r  <= motor_nxt;
      mtimer_r <= mtimer_nxt;
      msg_r    <= msg_nxt;
      lamps_r  <= lamps_nxt;
      lock_r   <= lock_nxt;
    end
  end

endmodule

@@ src/vending_controller_core.sv @@
// Top level of the vending controller: input register, event engine, result register.
// Depends on vc_pkg, vc_cfg_regs and vc_engine.
//
//   Port group   Direction   Handshake          Payload
//   in_*         input       in_valid/in_ready  func, key_code
//   out_*        output      out_valid/out_ready status .. bank_quarters
//   cfg_*        input       cfg_we             cfg_index, cfg_wdata
//
// One item per cycle if out_ready stays high; each passes the input and result registers.
// The item is processed as it moves from the input register to the result register,
// and the machine state is updated in that same cycle.
// A stalled result register holds its item; the input register still takes one more.
// Synchronous active-low reset restores state, settings and valid flags, not the data registers.
module vending_controller_core #(
  parameter int NUM_ITEMS   = vc_pkg::NUM_ITEMS_DEF,
  parameter int CODE_DIGITS = vc_pkg::CODE_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [3:0]                in_key_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                out_status,
  output logic [3:0]                out_motor_enables,
  output logic                      out_servo_on,
  output logic                      out_red_led,
  output logic                      out_green_led,
  output logic [7:0]                out_credit_quarters,
  output logic [7:0]                out_change_quarters,
  output logic [2:0]                out_menu_mode,
  output logic [15:0]               out_bank_quarters,
  input  logic                      cfg_we,
  input  logic [vc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [vc_pkg::CFG_DW-1:0] cfg_wdata
);

  vc_pkg::cfg_t    cfg;
  vc_pkg::result_t res;
  vc_pkg::result_t res_r;
  logic            in_v_r, in_v_nxt;
  logic            out_v_r, out_v_nxt;
  logic [1:0]      func_r;
  logic [3:0]      key_r;
  logic            advance;
  logic            take;

  vc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vc_engine #(
    .NUM_ITEMS   (NUM_ITEMS),
    .CODE_DIGITS (CODE_DIGITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .func  (func_r),
    .key   (key_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    in_v_nxt  = take ? 1'b1 : (advance ? 1'b0 : in_v_r);
    out_v_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func_r <= in_func;
      key_r  <= in_key_code;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_status          = res_r.status;
  assign out_motor_enables   = res_r.motor_enables;
  assign out_servo_on        = res_r.servo_on;
  assign out_red_led         = res_r.red_led;
  assign out_green_led       = res_r.green_led;
  assign out_credit_quarters = res_r.credit_quarters;
  assign out_change_quarters = res_r.change_quarters;
  assign out_menu_mode       = res_r.menu_mode;
  assign out_bank_quarters   = res_r.bank_quarters;

endmodule

@@ src/vc_checker.sv @@
// Port-level checks of the vending controller, bound to the top level.
// Depends on vc_pkg for status codes.
module vc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_status,
  input logic        out_servo_on,
  input logic        out_red_led,
  input logic        out_green_led,
  input logic [7:0]  out_credit_quarters,
  input logic [7:0]  out_change_quarters
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_credit_quarters))
    else $error("stalled item changed");

  a_dispense_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vc_pkg::ST_DISPENSED
      |-> out_green_led && !out_red_led && out_credit_quarters == 8'd0)
    else $error("dispense without green lamp or with credit left");

  a_short_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == vc_pkg::ST_NOT_ENOUGH
      || out_status == vc_pkg::ST_NO_STOCK) |-> out_red_led && !out_green_led)
    else $error("refused selection without red lamp");

  a_change_servo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_change_quarters != 8'd0
      |-> out_status == vc_pkg::ST_DISPENSED && out_servo_on)
    else $error("change due without dispense or coin release");

endmodule

bind vending_controller_core vc_checker u_vc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_servo_on        (out_servo_on),
  .out_red_led         (out_red_led),
  .out_green_led       (out_green_led),
  .out_credit_quarters (out_credit_quarters),
  .out_change_quarters (out_change_quarters)
);

@@ dv/vc_result_checker.sv @@
// Result checker for the vending controller: keeps its own copy of the machine
// state and settings, predicts the result of every accepted item and compares.
// Depends on vc_pkg.
module vc_result_checker
  import vc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [3:0]        in_key_code,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [3:0]        out_status,
  input  logic [3:0]        out_motor_enables,
  input  logic              out_servo_on,
  input  logic              out_red_led,
  input  logic              out_green_led,
  input  logic [7:0]        out_credit_quarters,
  input  logic [7:0]        out_change_quarters,
  input  logic [2:0]        out_menu_mode,
  input  logic [15:0]       out_bank_quarters,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                results_owed,
  output int                mismatches
);

  logic [7:0]  price [NUM_ITEMS_DEF];
  logic [23:0] passcode;
  logic [7:0]  refill_level;
  logic [3:0]  motor_limit;

  mode_t       menu;
  logic [7:0]  credit;
  logic [7:0]  stock [NUM_ITEMS_DEF];
  logic [15:0] bank;
  logic [3:0]  entered [CODE_DIGITS_DEF];
  int          entry_pos;
  logic [7:0]  coins_due;
  logic [3:0]  motors;
  logic [3:0]  motor_count;
  logic [1:0]  msg_age;
  logic        red;
  logic        green;
  logic        keys_locked;

  result_t     owed_results [$];
  int          error_total = 0;

  task automatic back_to_main();
    menu = MODE_MAIN;
    msg_age = MSG_IDLE;
    red = 1'b0;
    green = 1'b0;
    keys_locked = 1'b0;
  endtask

  task automatic reset_machine();
    price[0] = PRICE_ONE_RST;
    price[1] = PRICE_TWO_RST;
    price[2] = PRICE_THREE_RST;
    price[3] = PRICE_FOUR_RST;
    passcode = ADMIN_CODE_RST;
    refill_level = RESTOCK_LEVEL_RST;
    motor_limit = MOTOR_TICKS_RST;
    foreach (stock[i]) stock[i] = RESTOCK_LEVEL_RST;
    credit = '0;
    bank = '0;
    foreach (entered[i]) entered[i] = '0;
    entry_pos = 0;
    coins_due = '0;
    motors = '0;
    motor_count = '0;
    back_to_main();
  endtask

  task automatic write_setting(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    case (idx)
      REG_PRICE_ONE:     price[0] = data[7:0];
      REG_PRICE_TWO:     price[1] = data[7:0];
      REG_PRICE_THREE:   price[2] = data[7:0];
      REG_PRICE_FOUR:    price[3] = data[7:0];
      REG_ADMIN_CODE:    passcode = data[23:0];
      REG_RESTOCK_LEVEL: refill_level = data[7:0];
      REG_MOTOR_TICKS:   motor_limit = data[3:0];
      default: ;
    endcase
  endtask

  function automatic logic passcode_entered();
    for (int i = 0; i < CODE_DIGITS_DEF; i++)
      if (entered[i] != passcode[(CODE_DIGITS_DEF - 1 - i) * 4 +: 4]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic next_result(input logic [1:0] f, input logic [3:0] k, output result_t r);
    status_t     st;
    logic [7:0]  change;
    logic [7:0]  cost;
    logic [16:0] sum;
    int          idx;
    st = ST_NONE;
    change = '0;
    if (f == FUNC_KEY) begin
      case (menu)
        MODE_CODE: begin
          if (k == KEY_HASH) begin
            entry_pos = 0;
            if (passcode_entered()) begin
              foreach (entered[i]) entered[i] = '0;
              menu = MODE_ADMIN;
              st = ST_CODE_OK;
            end else begin
              st = ST_CODE_BAD;
            end
          end else if (k == KEY_STAR) begin
            back_to_main();
            st = ST_MODE;
          end else begin
            if (entry_pos >= CODE_DIGITS_DEF) entry_pos = 0;
            entered[entry_pos] = k;
            entry_pos++;
            st = ST_DIGIT;
          end
        end
        MODE_ADMIN: begin
          case (k)
            KEY_STAR: begin
              back_to_main();
              st = ST_MODE;
            end
            4'd1: begin
              menu = MODE_TEMP;
              st = ST_MODE;
            end
            4'd2: begin
              menu = MODE_INVENTORY;
              st = ST_MODE;
            end
            4'd3: begin
              menu = MODE_CASH;
              st = ST_MODE;
            end
            default: ;
          endcase
        end
        MODE_TEMP: begin
          if (k == KEY_STAR) begin
            menu = MODE_ADMIN;
            st = ST_MODE;
          end
        end
        MODE_INVENTORY: begin
          if (k == KEY_STAR) begin
            menu = MODE_ADMIN;
            st = ST_MODE;
          end else if (k == KEY_HASH) begin
            foreach (stock[i]) stock[i] = refill_level;
            st = ST_RESTOCKED;
          end
        end
        MODE_CASH: begin
          if (k == KEY_STAR) begin
            menu = MODE_ADMIN;
            st = ST_MODE;
          end else if (k == KEY_HASH) begin
            coins_due = WITHDRAW_COINS;
            bank = '0;
            st = ST_WITHDRAWN;
          end
        end
        default: begin
          menu = MODE_MAIN;
          if (!keys_locked) begin
            if (k >= 1 && k <= NUM_ITEMS_DEF && k <= SEL_LIMIT) begin
              idx = k - 1;
              cost = price[idx];
              msg_age = '0;
              if (stock[idx] == 0) begin
                red = 1'b1;
                green = 1'b0;
                st = ST_NO_STOCK;
              end else begin
                keys_locked = 1'b1;
                if (credit >= cost) begin
                  sum = {1'b0, bank} + {9'd0, cost};
                  stock[idx] = stock[idx] - 8'd1;
                  bank = (sum > {1'b0, BANK_MAX}) ? BANK_MAX : sum[15:0];
                  motors[idx] = 1'b1;
                  motor_count = '0;
                  change = credit - cost;
                  coins_due = change;
                  credit = '0;
                  red = 1'b0;
                  green = 1'b1;
                  st = ST_DISPENSED;
                end else begin
                  red = 1'b1;
                  green = 1'b0;
                  st = ST_NOT_ENOUGH;
                end
              end
            end else if (k == KEY_STAR) begin
              menu = MODE_CODE;
              entry_pos = 0;
              st = ST_MODE;
            end
          end
        end
      endcase
    end else if (f == FUNC_COIN) begin
      if (credit != CREDIT_MAX) credit = credit + 8'd1;
    end else if (f == FUNC_REFUND) begin
      if (menu == MODE_MAIN) credit = '0;
    end else begin
      if (msg_age < MSG_IDLE) begin
        msg_age = msg_age + 2'd1;
        if (msg_age == MSG_IDLE) begin
          red = 1'b0;
          green = 1'b0;
          keys_locked = 1'b0;
        end
      end
      if (motors != 0) begin
        if (motor_count >= motor_limit) begin
          motors = '0;
          motor_count = '0;
        end else begin
          motor_count = motor_count + 4'd1;
        end
      end
      if (coins_due != 0) coins_due = coins_due - 8'd1;
    end
    r.status = st;
    r.motor_enables = motors;
    r.servo_on = (coins_due != 0);
    r.red_led = red;
    r.green_led = green;
    r.credit_quarters = credit;
    r.change_quarters = change;
    r.menu_mode = menu;
    r.bank_quarters = bank;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      error_total++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      reset_machine();
      owed_results.delete();
    end else begin
      if (cfg_we) write_setting(cfg_index, cfg_wdata);
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          error_total++;
          $display("%0t: result with no item outstanding, expected none, actual status %0d",
                   $time, out_status);
        end else begin
          want = owed_results.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("motor_enables", want.motor_enables, out_motor_enables);
          compare_field("servo_on", want.servo_on, out_servo_on);
          compare_field("red_led", want.red_led, out_red_led);
          compare_field("green_led", want.green_led, out_green_led);
          compare_field("credit_quarters", want.credit_quarters, out_credit_quarters);
          compare_field("change_quarters", want.change_quarters, out_change_quarters);
          compare_field("menu_mode", want.menu_mode, out_menu_mode);
          compare_field("bank_quarters", want.bank_quarters, out_bank_quarters);
        end
      end
      if (in_valid && in_ready) begin
        next_result(in_func, in_key_code, want);
        owed_results.push_back(want);
      end
    end
    results_owed <= owed_results.size();
    mismatches <= error_total;
  end

endmodule

@@ dv/testbench.sv @@
// Top of the vending controller testbench: clock, reset, settings, event stimulus
// with random gaps, and the verdict. Depends on vc_pkg, vending_controller_core
// and vc_result_checker.
module testbench;
  import vc_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_func;
  logic [3:0]        in_key_code;
  logic              out_valid;
  logic              out_ready;
  logic [3:0]        out_status;
  logic [3:0]        out_motor_enables;
  logic              out_servo_on;
  logic              out_red_led;
  logic              out_green_led;
  logic [7:0]        out_credit_quarters;
  logic [7:0]        out_change_quarters;
  logic [2:0]        out_menu_mode;
  logic [15:0]       out_bank_quarters;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  int          results_owed;
  int          mismatches;
  int          items_sent = 0;
  bit          calm = 1'b0;
  logic [23:0] code_now;

  vending_controller_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_key_code         (in_key_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_motor_enables   (out_motor_enables),
    .out_servo_on        (out_servo_on),
    .out_red_led         (out_red_led),
    .out_green_led       (out_green_led),
    .out_credit_quarters (out_credit_quarters),
    .out_change_quarters (out_change_quarters),
    .out_menu_mode       (out_menu_mode),
    .out_bank_quarters   (out_bank_quarters),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  vc_result_checker result_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_key_code         (in_key_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_motor_enables   (out_motor_enables),
    .out_servo_on        (out_servo_on),
    .out_red_led         (out_red_led),
    .out_green_led       (out_green_led),
    .out_credit_quarters (out_credit_quarters),
    .out_change_quarters (out_change_quarters),
    .out_menu_mode       (out_menu_mode),
    .out_bank_quarters   (out_bank_quarters),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .results_owed        (results_owed),
    .mismatches          (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] rand_key();
    return 4'($urandom_range(0, 15));
  endfunction

  // Any key the code entry stores, leaving out star and hash.
  function automatic logic [3:0] rand_digit();
    int r;
    r = $urandom_range(0, 13);
    return 4'(r >= 10 ? r + 2 : r);
  endfunction

  function automatic logic [7:0] rand_price();
    if ($urandom_range(0, 9) == 0) return 8'hFF;
    return 8'($urandom_range(0, 10));
  endfunction

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        hold_left = idle_length();
        out_ready <= (hold_left == 0);
      end
    end
  end

  task automatic send_event(input func_t f, input logic [3:0] k);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_key_code <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] p1, input logic [7:0] p2,
                               input logic [7:0] p3, input logic [7:0] p4,
                               input logic [23:0] code, input logic [7:0] level,
                               input logic [3:0] ticks);
    write_reg(REG_PRICE_ONE, CFG_DW'(p1));
    write_reg(REG_PRICE_TWO, CFG_DW'(p2));
    write_reg(REG_PRICE_THREE, CFG_DW'(p3));
    write_reg(REG_PRICE_FOUR, CFG_DW'(p4));
    write_reg(REG_ADMIN_CODE, CFG_DW'(code));
    write_reg(REG_RESTOCK_LEVEL, CFG_DW'(level));
    write_reg(REG_MOTOR_TICKS, CFG_DW'(ticks));
    code_now = code;
  endtask

  task automatic enter_code(input logic [23:0] code);
    for (int i = 5; i >= 0; i--) send_event(FUNC_KEY, code[i * 4 +: 4]);
  endtask

  task automatic program_phase(input int phase);
    logic [23:0] code;
    case (phase)
      0: load_settings(PRICE_ONE_RST, PRICE_TWO_RST, PRICE_THREE_RST, PRICE_FOUR_RST,
                       ADMIN_CODE_RST, RESTOCK_LEVEL_RST, MOTOR_TICKS_RST);
      1: load_settings(8'd0, 8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 4'd1);
      2: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 8'hFF, 4'd15);
      default: begin
        for (int i = 0; i < 6; i++) code[i * 4 +: 4] = rand_digit();
        if ($urandom_range(0, 3) == 0) code = 24'($urandom());
        load_settings(rand_price(), rand_price(), rand_price(), rand_price(), code,
                      ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 6)),
                      4'($urandom_range(1, 15)));
      end
    endcase
  endtask

  task automatic random_sequence();
    int   pick;
    logic good;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      repeat ($urandom_range(0, 12)) send_event(FUNC_COIN, rand_key());
      if ($urandom_range(0, 7) == 0) send_event(FUNC_REFUND, rand_key());
      send_event(FUNC_KEY, 4'($urandom_range(1, NUM_ITEMS_DEF)));
      repeat ($urandom_range(0, 4)) send_event(FUNC_TICK, rand_key());
    end else if (pick < 52) begin
      repeat (3) send_event(FUNC_TICK, rand_key());
      send_event(FUNC_KEY, KEY_STAR);
      good = ($urandom_range(0, 3) != 0);
      if (good) enter_code(code_now);
      else repeat ($urandom_range(1, 9)) send_event(FUNC_KEY, rand_digit());
      send_event(FUNC_KEY, KEY_HASH);
      if (good) begin
        repeat ($urandom_range(1, 3)) begin
          send_event(FUNC_KEY, 4'($urandom_range(1, 3)));
          if ($urandom_range(0, 3) == 0) send_event(FUNC_KEY, rand_key());
          if ($urandom_range(0, 1) == 0) send_event(FUNC_KEY, KEY_HASH);
          send_event(FUNC_KEY, KEY_STAR);
        end
      end
      send_event(FUNC_KEY, KEY_STAR);
    end else if (pick < 67) begin
      repeat ($urandom_range(1, 6)) send_event(FUNC_TICK, rand_key());
    end else if (pick < 77) begin
      repeat ($urandom_range(1, 5))
        send_event(($urandom_range(0, 2) == 0) ? FUNC_REFUND : FUNC_COIN, rand_key());
    end else begin
      repeat ($urandom_range(1, 6)) send_event(func_t'(2'($urandom_range(0, 3))), rand_key());
    end
  endtask

  initial begin
    int phase_end;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_KEY;
    in_key_code <= 4'd0;
    cfg_we <= 1'b0;
    cfg_index <= REG_PRICE_ONE;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturate the credit and make full-price sales from it.
    load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, ADMIN_CODE_RST, 8'hFF, 4'd15);
    calm = 1'b1;
    send_event(FUNC_KEY, KEY_STAR);
    enter_code(ADMIN_CODE_RST);
    send_event(FUNC_KEY, KEY_HASH);
    send_event(FUNC_KEY, 4'd2);
    send_event(FUNC_KEY, KEY_HASH);
    send_event(FUNC_KEY, KEY_STAR);
    send_event(FUNC_KEY, KEY_STAR);
    for (int n = 0; n < 2; n++) begin
      repeat (256) send_event(FUNC_COIN, rand_key());
      send_event(FUNC_KEY, 4'(n % NUM_ITEMS_DEF + 1));
      repeat (3) send_event(FUNC_TICK, rand_key());
    end
    calm = 1'b0;
    settle();

    load_settings(8'd0, 8'hFF, 8'd2, 8'd1, 24'hF0C9D1, 8'd1, 4'd1);
    send_event(FUNC_KEY, KEY_STAR);
    send_event(FUNC_KEY, KEY_HASH);
    enter_code(24'hF0C9D1);
    send_event(FUNC_KEY, KEY_HASH);
    send_event(FUNC_KEY, 4'd2);
    send_event(FUNC_KEY, KEY_HASH);
    send_event(FUNC_KEY, KEY_STAR);
    send_event(FUNC_KEY, 4'd3);
    send_event(FUNC_KEY, KEY_HASH);
    send_event(FUNC_COIN, 4'd15);
    send_event(FUNC_REFUND, 4'd0);
    send_event(FUNC_KEY, KEY_STAR);
    send_event(FUNC_KEY, KEY_STAR);
    send_event(FUNC_KEY, 4'd2);
    send_event(FUNC_KEY, KEY_STAR);
    repeat (3) send_event(FUNC_TICK, 4'd0);
    send_event(FUNC_KEY, 4'd1);
    repeat (3) send_event(FUNC_TICK, 4'd15);
    send_event(FUNC_KEY, 4'd1);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      program_phase(phase);
      calm = (phase == 4);
      phase_end = items_sent + 150;
      while (items_sent < phase_end) random_sequence();
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
